// ===== rtl/tsmc_pkg.sv =====
// Shared types, constants and the exp2 root table for the sliding mode speed core.
// No dependencies; every other file imports this package.
`default_nettype none
package tsmc_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int DT_INV = 10000;
   localparam int M_INV_DEN = 363;

   // ceil(2^45 / 10000): exact quotient for magnitudes up to 2^31
   localparam logic [31:0] RECIP_DT = 32'hD1B7_1759;
   // ceil(5 * 2^40 / 363): exact scaled quotient for magnitudes up to 2^32
   localparam logic [33:0] RECIP_MINV = 34'h3_86B3_2126;

   // register map
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LAMBDA_ONE = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LAMBDA_TWO = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ALPHA_ONE = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ALPHA_TWO = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ALPHA_THREE = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_LINEAR = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_POWER = 3'd6;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_PREP, OP_PSETUP, OP_NORM, OP_LOG, OP_MULA, OP_EXP,
      OP_EFIN, OP_GAIN, OP_SUMS, OP_LIN, OP_SUMR, OP_DIVLD_R, OP_DIV, OP_INTEG,
      OP_DIVLD_C, OP_DIVFIN, OP_OUT
   } op_type;

   typedef enum logic [1:0] {
      TERM_DERIV, TERM_ERROR, TERM_SURFACE
   } term_type;

   typedef enum logic {
      DIV_DT, DIV_MINV
   } div_sel_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_PREP, ST_PSETUP, ST_NORM, ST_LOG, ST_MULA, ST_EXP, ST_EFIN,
      ST_GAIN, ST_SUMS, ST_LIN, ST_SUMR, ST_DIVLD_R, ST_DIV_R, ST_INTEG,
      ST_DIVLD_C, ST_DIV_C, ST_DIVFIN_C, ST_OUT
   } state_type;

   typedef struct packed {
      op_type      op;
      term_type    term;
      logic [5:0]  step;
      div_sel_type div_sel;
   } cmd_type;

   typedef struct packed {
      logic pzero;
   } status_type;

   typedef logic [15:0][31:0] root_tbl_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      logic [63:0] rem;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      rem = v;
      for (int i = 0; i < 32; i++) begin
         if (rem >= r + b) begin
            rem = rem - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2^(2^-k) in Q2.30 for k = 1..16, by repeated square roots of 2
   function automatic root_tbl_type root_table();
      root_tbl_type tbl;
      logic [63:0] root;
      root = 64'h8000_0000;
      for (int k = 0; k < 16; k++) begin
         root = isqrt64(root << 30);
         tbl[k] = root[31:0];
      end
      return tbl;
   endfunction

   localparam root_tbl_type ROOTS = root_table();

endpackage
`default_nettype wire

// ===== rtl/tsmc_req_if.sv =====
// Input channel: speed target and measured speed with valid/ready.
// Depends on tsmc_pkg for the word width.
`default_nettype none
interface tsmc_req_if;
   import tsmc_pkg::*;
   logic valid;
   logic ready;
   logic signed [DATA_WIDTH-1:0] speed_target;
   logic signed [DATA_WIDTH-1:0] speed_measured;
   modport source (output valid, output speed_target, output speed_measured, input ready);
   modport sink (input valid, input speed_target, input speed_measured, output ready);
endinterface
`default_nettype wire

// ===== rtl/tsmc_rsp_if.sv =====
// Result channel: current command, surface value and speed error with valid/ready.
// Depends on tsmc_pkg for the word width.
`default_nettype none
interface tsmc_rsp_if;
   import tsmc_pkg::*;
   logic valid;
   logic ready;
   logic signed [DATA_WIDTH-1:0] current_command;
   logic signed [DATA_WIDTH-1:0] surface_value;
   logic signed [DATA_WIDTH-1:0] speed_error;
   modport source (output valid, output current_command, output surface_value,
                   output speed_error, input ready);
   modport sink (input valid, input current_command, input surface_value,
                 input speed_error, output ready);
endinterface
`default_nettype wire

// ===== rtl/tsmc_datapath.sv =====
// Datapath: config registers, controller state, shared 32x32 multiplier,
// log2/exp2 iteration registers and reciprocal constant dividers. Uses tsmc_pkg.
`default_nettype none
module tsmc_datapath
   import tsmc_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_write,
   input  wire logic [CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [DATA_WIDTH-1:0]        csr_data,
   input  wire cmd_type                      cmd,
   output status_type                        status,
   input  wire logic signed [DATA_WIDTH-1:0] req_target,
   input  wire logic signed [DATA_WIDTH-1:0] req_measured,
   output logic signed [DATA_WIDTH-1:0]      rsp_command,
   output logic signed [DATA_WIDTH-1:0]      rsp_surface,
   output logic signed [DATA_WIDTH-1:0]      rsp_error
);

   function automatic logic signed [31:0] sat_word(input logic signed [47:0] v);
      if (v > 48'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -48'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // (gain*p)>>16, clamped, then signed
   function automatic logic signed [31:0] gain_out(input logic [63:0] p, input logic neg);
      logic [31:0] mag;
      mag = (p[63:16] > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : p[47:16];
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

   logic [31:0] lambda_one_ff, lambda_two_ff, gain_linear_ff, gain_power_ff;
   logic [15:0] alpha_one_ff, alpha_two_ff, alpha_three_ff;
   logic signed [31:0] last_t_ff, last_t_in, last_m_ff, last_m_in, integ_ff, integ_in;

   logic signed [31:0] t_ff, t_in, m_ff, m_in;
   logic signed [31:0] err_ff, err_in, edot_ff, edot_in, rdot_ff, rdot_in;
   logic signed [31:0] termd_ff, termd_in, terme_ff, terme_in;
   logic signed [31:0] rpow_ff, rpow_in, rlin_ff, rlin_in;
   logic signed [31:0] s_ff, s_in, xeq_ff, xeq_in, reach_ff, reach_in;
   logic [31:0] mag_ff, mag_in, mant_ff, mant_in, acc_ff, acc_in, pwr_ff, pwr_in;
   logic        xneg_ff, xneg_in, dneg_ff, dneg_in;
   logic [4:0]  n_ff, n_in;
   logic [15:0] frac_ff, frac_in;
   logic signed [23:0] y_ff, y_in;
   logic [32:0] num_ff, num_in;
   logic [31:0] prod_ff, prod_in;
   logic signed [31:0] out_cmd_ff, out_cmd_in, out_s_ff, out_s_in, out_err_ff, out_err_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;

   always_comb begin
      mul_a = gain_power_ff;
      mul_b = pwr_ff;
      case (cmd.op)
         OP_LOG: begin
            mul_a = mant_ff;
            mul_b = mant_ff;
         end
         OP_EXP: begin
            mul_a = acc_ff;
            mul_b = ROOTS[cmd.step[3:0]];
         end
         OP_GAIN: begin
            case (cmd.term)
               TERM_DERIV: mul_a = lambda_one_ff;
               TERM_ERROR: mul_a = lambda_two_ff;
               default:    mul_a = gain_power_ff;
            endcase
            mul_b = pwr_ff;
         end
         OP_LIN: begin
            mul_a = gain_linear_ff;
            mul_b = s_ff[31] ? (~s_ff + 32'd1) : s_ff;
         end
         OP_DIV: begin
            mul_a = num_ff[31:0];
            mul_b = (cmd.div_sel == DIV_DT) ? RECIP_DT : RECIP_MINV[31:0];
         end
         default: begin
            mul_a = gain_power_ff;
            mul_b = pwr_ff;
         end
      endcase
      mul_p = 64'(mul_a) * 64'(mul_b);
   end

   assign status.pzero = (mag_ff == 32'd0);

   logic signed [35:0] dt, dm, de;
   logic signed [31:0] xsel;
   logic [15:0]        asel;
   logic [5:0]         sz;
   logic [31:0]        mask;
   logic [32:0]        sq_top;
   logic signed [5:0]  nd;
   logic signed [21:0] logv;
   logic signed [38:0] ap;
   logic signed [7:0]  ip;
   logic [7:0]         sh;
   logic [36:0]        cq;
   logic signed [47:0] wide, vmag;

   always_comb begin
      last_t_in = last_t_ff; last_m_in = last_m_ff; integ_in = integ_ff;
      t_in = t_ff; m_in = m_ff;
      err_in = err_ff; edot_in = edot_ff; rdot_in = rdot_ff;
      termd_in = termd_ff; terme_in = terme_ff; rpow_in = rpow_ff; rlin_in = rlin_ff;
      s_in = s_ff; xeq_in = xeq_ff; reach_in = reach_ff;
      mag_in = mag_ff; mant_in = mant_ff; acc_in = acc_ff; pwr_in = pwr_ff;
      xneg_in = xneg_ff; dneg_in = dneg_ff; n_in = n_ff; frac_in = frac_ff;
      y_in = y_ff; num_in = num_ff; prod_in = prod_ff;
      out_cmd_in = out_cmd_ff; out_s_in = out_s_ff; out_err_in = out_err_ff;

      dt = 36'(t_ff) - 36'(last_t_ff);
      dm = 36'(m_ff) - 36'(last_m_ff);
      de = dt - dm;
      case (cmd.term)
         TERM_DERIV: begin xsel = edot_ff; asel = alpha_one_ff; end
         TERM_ERROR: begin xsel = err_ff;  asel = alpha_two_ff; end
         default:    begin xsel = s_ff;    asel = alpha_three_ff; end
      endcase
      sz = 6'd16 >> cmd.step[2:0];
      mask = ~(32'hFFFF_FFFF >> sz);
      sq_top = mul_p[63:31];
      nd = $signed(6'({1'b0, n_ff})) - 6'sd16;
      logv = {nd, frac_ff};
      ap = 39'($signed({1'b0, asel})) * 39'(logv);
      ip = y_ff[23:16];
      sh = 8'(8'sd14 - ip);
      // finish the 33 x 34 bit reciprocal product from its low 32 x 32 part
      cq = 37'(prod_ff) + 37'(num_ff[31:0]) * 37'd3
           + (num_ff[32] ? 37'(RECIP_MINV) : 37'd0);
      wide = 48'(xeq_ff) + 48'(integ_ff);
      vmag = wide[47] ? -wide : wide;

      case (cmd.op)
         OP_LOAD: begin
            t_in = req_target;
            m_in = req_measured;
         end
         OP_PREP: begin
            err_in = sat_word(48'(t_ff) - 48'(m_ff));
            rdot_in = sat_word(48'(dt) * 48'sd10000);
            edot_in = sat_word(48'(de) * 48'sd10000);
            last_t_in = t_ff;
            last_m_in = m_ff;
         end
         OP_PSETUP: begin
            xneg_in = xsel[31];
            mag_in = xsel[31] ? (~xsel + 32'd1) : xsel;
            mant_in = xsel[31] ? (~xsel + 32'd1) : xsel;
            n_in = 5'd31;
            frac_in = '0;
            pwr_in = '0;
         end
         OP_NORM: begin
            if ((mant_ff & mask) == 32'd0) begin
               mant_in = mant_ff << sz;
               n_in = n_ff - 5'(sz);
            end
         end
         OP_LOG: begin
            // square, keep one bit per step
            if (sq_top[32]) begin
               frac_in = {frac_ff[14:0], 1'b1};
               mant_in = sq_top[32:1];
            end else begin
               frac_in = {frac_ff[14:0], 1'b0};
               mant_in = sq_top[31:0];
            end
         end
         OP_MULA: begin
            y_in = ap[38:15];
            acc_in = 32'h4000_0000;
         end
         OP_EXP: begin
            if (y_ff[4'd15 - cmd.step[3:0]]) acc_in = mul_p[61:30];
         end
         OP_EFIN: begin
            if (ip > 8'sd14) pwr_in = 32'h7FFF_FFFF;
            else if (sh >= 8'd32) pwr_in = '0;
            else pwr_in = acc_ff >> sh[4:0];
         end
         OP_GAIN: begin
            case (cmd.term)
               TERM_DERIV: termd_in = gain_out(mul_p, xneg_ff);
               TERM_ERROR: terme_in = gain_out(mul_p, xneg_ff);
               default:    rpow_in = gain_out(mul_p, xneg_ff);
            endcase
         end
         OP_SUMS: begin
            s_in = sat_word(48'(edot_ff) + 48'(termd_ff) + 48'(terme_ff));
            xeq_in = sat_word(48'(rdot_ff) + 48'(termd_ff) + 48'(terme_ff));
         end
         OP_LIN: rlin_in = gain_out(mul_p, s_ff[31]);
         OP_SUMR: reach_in = sat_word(48'(rlin_ff) + 48'(rpow_ff));
         OP_DIVLD_R: begin
            dneg_in = reach_ff[31];
            num_in = {1'b0, reach_ff[31] ? (~reach_ff + 32'd1) : reach_ff};
         end
         OP_DIV: begin
            if (cmd.div_sel == DIV_DT) num_in = 33'(mul_p[63:45]);
            else prod_in = mul_p[63:32];
         end
         OP_INTEG: begin
            integ_in = sat_word(dneg_ff ? (48'(integ_ff) - $signed({16'd0, num_ff[31:0]}))
                                        : (48'(integ_ff) + $signed({16'd0, num_ff[31:0]})));
         end
         OP_DIVLD_C: begin
            dneg_in = wide[47];
            num_in = vmag[32:0];
         end
         OP_DIVFIN: num_in = 33'(cq[36:8]);
         OP_OUT: begin
            out_cmd_in = dneg_ff ? -$signed(num_ff[31:0]) : $signed(num_ff[31:0]);
            out_s_in = s_ff;
            out_err_in = err_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lambda_one_ff <= 32'd65536;
         lambda_two_ff <= 32'd65536;
         alpha_one_ff <= 16'd32768;
         alpha_two_ff <= 16'd32768;
         alpha_three_ff <= 16'd32768;
         gain_linear_ff <= 32'd65536;
         gain_power_ff <= 32'd65536;
         last_t_ff <= '0;
         last_m_ff <= '0;
         integ_ff <= '0;
      end else begin
         last_t_ff <= last_t_in;
         last_m_ff <= last_m_in;
         integ_ff <= integ_in;
         if (csr_write) begin
            case (csr_index)
               CSR_LAMBDA_ONE:  lambda_one_ff <= csr_data;
               CSR_LAMBDA_TWO:  lambda_two_ff <= csr_data;
               CSR_ALPHA_ONE:   alpha_one_ff <= csr_data[15:0];
               CSR_ALPHA_TWO:   alpha_two_ff <= csr_data[15:0];
               CSR_ALPHA_THREE: alpha_three_ff <= csr_data[15:0];
               CSR_GAIN_LINEAR: gain_linear_ff <= csr_data;
               CSR_GAIN_POWER:  gain_power_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in; m_ff <= m_in;
      err_ff <= err_in; edot_ff <= edot_in; rdot_ff <= rdot_in;
      termd_ff <= termd_in; terme_ff <= terme_in; rpow_ff <= rpow_in; rlin_ff <= rlin_in;
      s_ff <= s_in; xeq_ff <= xeq_in; reach_ff <= reach_in;
      mag_ff <= mag_in; mant_ff <= mant_in; acc_ff <= acc_in; pwr_ff <= pwr_in;
      xneg_ff <= xneg_in; dneg_ff <= dneg_in; n_ff <= n_in; frac_ff <= frac_in;
      y_ff <= y_in; num_ff <= num_in; prod_ff <= prod_in;
      out_cmd_ff <= out_cmd_in; out_s_ff <= out_s_in; out_err_ff <= out_err_in;
   end

   assign rsp_command = out_cmd_ff;
   assign rsp_surface = out_s_ff;
   assign rsp_error = out_err_ff;

endmodule
`default_nettype wire

// ===== rtl/tsmc_ctrl.sv =====
// Sequencer: walks one sample through the power, sum and divide steps and
// owns the channel handshakes. Uses tsmc_pkg.
`default_nettype none
module tsmc_ctrl
   import tsmc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type   state_ff, state_in;
   term_type    term_ff, term_in;
   logic [5:0]  step_ff, step_in;
   logic        rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         term_ff <= TERM_DERIV;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         term_ff <= term_in;
         step_ff <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      term_in = term_ff;
      step_in = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready = 1'b0;
      cmd.op = OP_NONE;
      cmd.term = term_ff;
      cmd.step = step_ff;
      cmd.div_sel = DIV_DT;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = OP_LOAD;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.op = OP_PREP;
            term_in = TERM_DERIV;
            state_in = ST_PSETUP;
         end
         ST_PSETUP: begin
            cmd.op = OP_PSETUP;
            step_in = '0;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            // zero base: power stays zero, skip the iterations
            if (step_ff == 6'd0 && status.pzero) begin
               state_in = ST_GAIN;
            end else begin
               cmd.op = OP_NORM;
               if (step_ff == 6'd4) begin
                  step_in = '0;
                  state_in = ST_LOG;
               end else begin
                  step_in = step_ff + 6'd1;
               end
            end
         end
         ST_LOG: begin
            cmd.op = OP_LOG;
            if (step_ff == 6'd15) begin
               step_in = '0;
               state_in = ST_MULA;
            end else begin
               step_in = step_ff + 6'd1;
            end
         end
         ST_MULA: begin
            cmd.op = OP_MULA;
            step_in = '0;
            state_in = ST_EXP;
         end
         ST_EXP: begin
            cmd.op = OP_EXP;
            if (step_ff == 6'd15) begin
               step_in = '0;
               state_in = ST_EFIN;
            end else begin
               step_in = step_ff + 6'd1;
            end
         end
         ST_EFIN: begin
            cmd.op = OP_EFIN;
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.op = OP_GAIN;
            case (term_ff)
               TERM_DERIV: begin
                  term_in = TERM_ERROR;
                  state_in = ST_PSETUP;
               end
               TERM_ERROR: state_in = ST_SUMS;
               default:    state_in = ST_LIN;
            endcase
         end
         ST_SUMS: begin
            cmd.op = OP_SUMS;
            term_in = TERM_SURFACE;
            state_in = ST_PSETUP;
         end
         ST_LIN: begin
            cmd.op = OP_LIN;
            state_in = ST_SUMR;
         end
         ST_SUMR: begin
            cmd.op = OP_SUMR;
            state_in = ST_DIVLD_R;
         end
         ST_DIVLD_R: begin
            cmd.op = OP_DIVLD_R;
            state_in = ST_DIV_R;
         end
         ST_DIV_R: begin
            cmd.op = OP_DIV;
            cmd.div_sel = DIV_DT;
            state_in = ST_INTEG;
         end
         ST_INTEG: begin
            cmd.op = OP_INTEG;
            state_in = ST_DIVLD_C;
         end
         ST_DIVLD_C: begin
            cmd.op = OP_DIVLD_C;
            state_in = ST_DIV_C;
         end
         ST_DIV_C: begin
            cmd.op = OP_DIV;
            cmd.div_sel = DIV_MINV;
            state_in = ST_DIVFIN_C;
         end
         ST_DIVFIN_C: begin
            cmd.op = OP_DIVFIN;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== rtl/terminal_sliding_mode_speed_control_core.sv =====
// Terminal sliding mode speed controller, signed Q16.16. One sample is taken at a
// time and runs to a result beat in the output register; the iterations of a
// power term are skipped when its base (e', e or s) is zero. Once the result is
// written the controller returns to idle to accept the next sample. The shared
// 32x32 multiplier runs 5 normalize, 16 log2 and 16 exp2 steps for each of the
// three power terms; the integrator and current scaling divide by reciprocal
// multiplication. A finished beat waits in the output register while the next
// sample is accepted; a sample that finishes before that beat is taken holds
// until it is. Depends on tsmc_pkg and the channel interfaces.
`default_nettype none
module terminal_sliding_mode_speed_control_core
   import tsmc_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   tsmc_req_if.sink                        req_chan,
   tsmc_rsp_if.source                      rsp_chan,
   input  wire logic                       csr_write,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [DATA_WIDTH-1:0]      csr_data
);

   cmd_type    cmd;
   status_type status;

   tsmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tsmc_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cmd          (cmd),
      .status       (status),
      .req_target   (req_chan.speed_target),
      .req_measured (req_chan.speed_measured),
      .rsp_command  (rsp_chan.current_command),
      .rsp_surface  (rsp_chan.surface_value),
      .rsp_error    (rsp_chan.speed_error)
   );

endmodule
`default_nettype wire

// ===== test/terminal_sliding_mode_speed_control_core_tb.sv =====
// Self-checking bench for the sliding mode speed core: predicts every result beat
// in Q16.16 and compares it with the response channel. Needs tsmc_pkg and both channel interfaces.
`timescale 1ns / 100ps
module terminal_sliding_mode_speed_control_core_tb;
   import tsmc_pkg::*;

   localparam longint WORD_MAX = 64'sd2147483647;
   localparam longint WORD_MIN = -64'sd2147483648;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam int SETTLE_CYCLES = 300;

   typedef struct {
      logic signed [31:0] target;
      logic signed [31:0] measured;
   } speed_beat_t;

   typedef struct {
      logic signed [31:0] command;
      logic signed [31:0] surface;
      logic signed [31:0] error;
   } control_beat_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [DATA_WIDTH-1:0] csr_data = '0;

   tsmc_req_if req_bus();
   tsmc_rsp_if rsp_bus();

   terminal_sliding_mode_speed_control_core dut (
      .clock(clock), .reset(reset), .req_chan(req_bus), .rsp_chan(rsp_bus),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // controller copy: gains, exponents and history
   logic [63:0] k_lambda_one, k_lambda_two, k_gain_linear, k_gain_power;
   logic [15:0] k_alpha_one, k_alpha_two, k_alpha_three;
   longint hist_target, hist_measured, integral_sum;

   speed_beat_t   pending_speeds[$];
   control_beat_t expected_controls[$];
   int send_idle_pct = 9;
   int recv_idle_pct = 81;
   int mismatch_count = 0;
   longint cycle_count = 0;
   logic signed [31:0] walk_target = '0;
   speed_beat_t last_item;

   function automatic longint clamp_word(longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint log2_fix(logic [63:0] x);
      int n;
      longint frac;
      logic [63:0] mant;
      n = 31;
      frac = 0;
      while (n > 0 && !x[n]) n--;
      mant = x << (31 - n);
      for (int i = 0; i < 16; i++) begin
         mant = (mant * mant) >> 31;
         frac = frac << 1;
         if (mant >= 64'h1_0000_0000) begin
            frac = frac | 1;
            mant = mant >> 1;
         end
      end
      return longint'(n - 16) * 65536 + frac;
   endfunction

   function automatic logic [63:0] exp2_fix(longint y);
      longint ip, f;
      logic [63:0] root, acc;
      ip = y >>> 16;
      f = y - ip * 65536;
      root = 64'h8000_0000;
      acc = 64'h4000_0000;
      for (int k = 1; k <= 16; k++) begin
         root = int_sqrt(root << 30);
         if ((f >> (16 - k)) & 1) acc = (acc * root) >> 30;
      end
      if (ip > 14) return 64'h7FFF_FFFF;
      if (ip == 14) return acc;
      if (14 - ip >= 63) return 0;
      return acc >> (14 - ip);
   endfunction

   // signed gain * |x|^a (or gain * |x| for the linear term), saturated
   function automatic longint gain_term(logic [63:0] gain, longint x, logic [15:0] a,
                                        bit linear);
      logic [63:0] mag, p, prod;
      if (x == 0) return 0;
      mag = (x < 0) ? -x : x;
      if (linear) p = mag;
      else p = exp2_fix((longint'(a) * log2_fix(mag)) >>> 15);
      prod = (gain * p) >> 16;
      if (prod > 64'h7FFF_FFFF) prod = 64'h7FFF_FFFF;
      return (x < 0) ? -longint'(prod) : longint'(prod);
   endfunction

   function automatic control_beat_t predict_control(speed_beat_t b);
      control_beat_t c;
      longint t, m, err, ref_dot, err_dot, term_d, term_e, surf, reach, x_eq;
      t = longint'(b.target);
      m = longint'(b.measured);
      err = clamp_word(t - m);
      ref_dot = clamp_word((t - hist_target) * 10000);
      err_dot = clamp_word(((t - hist_target) - (m - hist_measured)) * 10000);
      term_d = gain_term(k_lambda_one, err_dot, k_alpha_one, 1'b0);
      term_e = gain_term(k_lambda_two, err, k_alpha_two, 1'b0);
      surf = clamp_word(err_dot + term_d + term_e);
      reach = clamp_word(gain_term(k_gain_linear, surf, 16'd0, 1'b1) +
                         gain_term(k_gain_power, surf, k_alpha_three, 1'b0));
      x_eq = clamp_word(ref_dot + term_d + term_e);
      integral_sum = clamp_word(integral_sum + reach / 10000);
      c.command = 32'(clamp_word(((x_eq + integral_sum) * 5) / 363));
      c.surface = 32'(surf);
      c.error = 32'(err);
      hist_target = t;
      hist_measured = m;
      return c;
   endfunction

   function automatic speed_beat_t make_speed(longint t, longint m);
      speed_beat_t b;
      b.target = 32'(t);
      b.measured = 32'(m);
      return b;
   endfunction

   function automatic logic signed [31:0] pick_extreme();
      case ($urandom_range(4))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return 32'sd0;
         3: return 32'sd1;
         default: return -32'sd1;
      endcase
   endfunction

   // half slow speed trajectories with a tracking error, plus holds, equal pairs, extremes and noise
   function automatic speed_beat_t random_speed();
      speed_beat_t b;
      int mode;
      mode = $urandom_range(9);
      if (mode <= 4) begin
         if ($urandom_range(19) == 0) walk_target = $signed($urandom_range(0, 2097152)) - 1048576;
         walk_target = walk_target + ($signed($urandom_range(0, 4000)) - 2000);
         b.target = walk_target;
         b.measured = walk_target + ($signed($urandom_range(0, 131072)) - 65536);
      end else if (mode == 5) begin
         b = last_item;
      end else if (mode == 6) begin
         b.target = $urandom;
         b.measured = b.target;
      end else if (mode == 7) begin
         b.target = pick_extreme();
         b.measured = pick_extreme();
      end else begin
         b.target = $urandom;
         b.measured = $urandom;
      end
      last_item = b;
      return b;
   endfunction

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      case (idx)
         CSR_LAMBDA_ONE:  k_lambda_one = 64'(value);
         CSR_LAMBDA_TWO:  k_lambda_two = 64'(value);
         CSR_ALPHA_ONE:   k_alpha_one = value[15:0];
         CSR_ALPHA_TWO:   k_alpha_two = value[15:0];
         CSR_ALPHA_THREE: k_alpha_three = value[15:0];
         CSR_GAIN_LINEAR: k_gain_linear = 64'(value);
         CSR_GAIN_POWER:  k_gain_power = 64'(value);
         default: ;
      endcase
   endtask

   task automatic load_gains(logic [31:0] l1, logic [31:0] l2, logic [31:0] a1,
                             logic [31:0] a2, logic [31:0] a3, logic [31:0] gl,
                             logic [31:0] gp);
      write_csr(CSR_LAMBDA_ONE, l1);
      write_csr(CSR_LAMBDA_TWO, l2);
      write_csr(CSR_ALPHA_ONE, a1);
      write_csr(CSR_ALPHA_TWO, a2);
      write_csr(CSR_ALPHA_THREE, a3);
      write_csr(CSR_GAIN_LINEAR, gl);
      write_csr(CSR_GAIN_POWER, gp);
   endtask

   task automatic end_csr_burst();
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic drain_and_settle();
      wait (pending_speeds.size() == 0 && !req_bus.valid && expected_controls.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_random(int count);
      for (int i = 0; i < count; i++) pending_speeds.push_back(random_speed());
   endtask

   // driver: advance on each accepted beat, predict it, maybe idle
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_controls.push_back(predict_control(
               make_speed(req_bus.speed_target, req_bus.speed_measured)));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_speeds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               speed_beat_t nb;
               nb = pending_speeds.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.speed_target <= nb.target;
               req_bus.speed_measured <= nb.measured;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: random backpressure, compare each beat against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_controls.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result beat: cmd %h surf %h err %h",
                           rsp_bus.current_command, rsp_bus.surface_value,
                           rsp_bus.speed_error);
            end else begin
               control_beat_t e;
               e = expected_controls.pop_front();
               if (e.command !== rsp_bus.current_command || e.surface !== rsp_bus.surface_value
                   || e.error !== rsp_bus.speed_error) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: cmd %h/%h surf %h/%h err %h/%h (expected/actual)",
                              e.command, rsp_bus.current_command, e.surface,
                              rsp_bus.surface_value, e.error, rsp_bus.speed_error);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[terminal_sliding_mode_speed_control_core] ERROR");
         $finish;
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.speed_target = '0;
      req_bus.speed_measured = '0;
      rsp_bus.ready = 1'b0;
      k_lambda_one = 65536; k_lambda_two = 65536;
      k_alpha_one = 16'd32768; k_alpha_two = 16'd32768; k_alpha_three = 16'd32768;
      k_gain_linear = 65536; k_gain_power = 65536;
      hist_target = 0; hist_measured = 0; integral_sum = 0;
      last_item = make_speed(0, 0);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset gains: zero inputs, holds, extremes and sign flips
      pending_speeds.push_back(make_speed(0, 0));
      pending_speeds.push_back(make_speed(0, 0));
      pending_speeds.push_back(make_speed(65536, 0));
      pending_speeds.push_back(make_speed(65536, 0));
      pending_speeds.push_back(make_speed(65536, 65536));
      pending_speeds.push_back(make_speed(1, 0));
      pending_speeds.push_back(make_speed(0, 1));
      pending_speeds.push_back(make_speed(-1, 0));
      pending_speeds.push_back(make_speed(WORD_MAX, WORD_MIN));
      pending_speeds.push_back(make_speed(WORD_MIN, WORD_MAX));
      pending_speeds.push_back(make_speed(WORD_MAX, WORD_MAX));
      pending_speeds.push_back(make_speed(WORD_MIN, WORD_MIN));
      pending_speeds.push_back(make_speed(WORD_MIN, 0));
      pending_speeds.push_back(make_speed(WORD_MAX, 0));
      pending_speeds.push_back(make_speed(0, WORD_MAX));
      pending_speeds.push_back(make_speed(100000, 98000));
      pending_speeds.push_back(make_speed(100100, 98500));
      pending_speeds.push_back(make_speed(100200, 99800));
      pending_speeds.push_back(make_speed(-300000, -290000));
      pending_speeds.push_back(make_speed(-300000, -290000));
      queue_random(60);
      drain_and_settle();

      // zero gains, then zero exponents: power terms vanish, then collapse to sign only
      load_gains(0, 0, 0, 0, 0, 0, 0);
      end_csr_burst();
      queue_random(120);
      drain_and_settle();
      load_gains(65536, 65536, 0, 0, 0, 65536, 65536);
      end_csr_burst();
      queue_random(150);
      drain_and_settle();

      send_idle_pct = 81;
      recv_idle_pct = 9;
      load_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      end_csr_burst();
      queue_random(250);
      drain_and_settle();
      load_gains($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end_csr_burst();
      queue_random(300);
      drain_and_settle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      // out-of-map index must not disturb the gains
      load_gains($urandom_range(0, 262144), $urandom_range(0, 262144), $urandom,
                 $urandom, $urandom, $urandom_range(0, 1048576), $urandom_range(0, 1048576));
      write_csr(3'd7, $urandom);
      end_csr_burst();
      queue_random(350);
      drain_and_settle();
      load_gains(32768, 16384, 20000, 24000, 16000, 200000, 150000);
      end_csr_burst();
      queue_random(450);
      drain_and_settle();

      if (mismatch_count == 0 && expected_controls.size() == 0) begin
         $display("[terminal_sliding_mode_speed_control_core] OK");
      end else begin
         $display("[terminal_sliding_mode_speed_control_core] ERROR");
      end
      $finish;
   end

endmodule
